// ----- hw/rtl/jsu_pkg.sv -----
`default_nettype none

package jsu_pkg;

   // Parser position inside a literal. Codes past the last member act as idle.
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_STR   = 3'd1,
      PH_ESC   = 3'd2,
      PH_HEXHI = 3'd3,
      PH_LOWBS = 3'd4,
      PH_LOWU  = 3'd5,
      PH_HEXLO = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_END  = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   localparam logic [3:0] ERR_NO_QUOTE     = 4'd0;
   localparam logic [3:0] ERR_INCOMPLETE   = 4'd1;
   localparam logic [3:0] ERR_SHORT_HEX    = 4'd2;
   localparam logic [3:0] ERR_BAD_HEX      = 4'd3;
   localparam logic [3:0] ERR_NO_LOW       = 4'd4;
   localparam logic [3:0] ERR_BAD_LOW      = 4'd5;
   localparam logic [3:0] ERR_LONE_LOW     = 4'd6;
   localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd7;
   localparam logic [3:0] ERR_CONTROL      = 4'd8;
   localparam logic [3:0] ERR_UNTERMINATED = 4'd9;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_U      = 8'h75;

   // At most four UTF-8 bytes and one end marker or error per source byte.
   localparam int MaxResults = 5;
   localparam int DataMax    = 4;
   localparam int CountW     = $clog2(MaxResults + 1);
   localparam int IdxW       = $clog2(MaxResults);

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [3:0] err;
      logic       last;
   } result_type;

   // All results caused by one source byte.
   typedef struct packed {
      logic [CountW-1:0]                count;
      result_type [MaxResults-1:0]      items;
   } group_type;

endpackage

`default_nettype wire

// ----- hw/rtl/jsu_decode.sv -----
`default_nettype none

module jsu_decode (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         in_byte,
   input  wire logic               in_final,
   input  wire logic               fire,
   output jsu_pkg::group_type      group
);

   jsu_pkg::phase_type phase_ff, phase_in;
   logic [1:0]         dig_ff, dig_in;
   logic [15:0]        acc_ff, acc_in;
   logic [9:0]         hs_ff, hs_in;

   logic [7:0]         dbytes [jsu_pkg::DataMax];
   logic [2:0]         nd;
   logic               tail;
   jsu_pkg::kind_type  tail_kind;
   logic [3:0]         tail_err;
   logic [4:0]         nib;
   logic [15:0]        val;
   logic [20:0]        cp;
   logic [8:0]         esc;
   logic               after_data;

   // Bit 4 set when the byte is not a hex digit.
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      logic [4:0] r;
      begin
         r = 5'h10;
         if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
         end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
         end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
         end
         return r;
      end
   endfunction

   always_comb begin
      nib = nibble_of(in_byte);
      val = {acc_ff[11:0], nib[3:0]};
      cp  = 21'h10000 + {1'b0, hs_ff, val[9:0]};
      unique case (in_byte)
         jsu_pkg::CH_QUOTE:  esc = {1'b0, jsu_pkg::CH_QUOTE};
         jsu_pkg::CH_BSLASH: esc = {1'b0, jsu_pkg::CH_BSLASH};
         jsu_pkg::CH_SLASH:  esc = {1'b0, jsu_pkg::CH_SLASH};
         8'h62:              esc = 9'h008;
         8'h66:              esc = 9'h00C;
         8'h6E:              esc = 9'h00A;
         8'h72:              esc = 9'h00D;
         8'h74:              esc = 9'h009;
         default:            esc = 9'h100;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      dig_in     = dig_ff;
      acc_in     = acc_ff;
      hs_in      = hs_ff;
      for (int i = 0; i < jsu_pkg::DataMax; i++) begin
         dbytes[i] = 8'h00;
      end
      nd         = 3'd0;
      tail       = 1'b0;
      tail_kind  = jsu_pkg::KIND_ERR;
      tail_err   = jsu_pkg::ERR_NO_QUOTE;
      after_data = 1'b0;

      unique case (phase_ff)
         jsu_pkg::PH_STR: begin
            if (in_byte == jsu_pkg::CH_QUOTE) begin
               tail      = 1'b1;
               tail_kind = jsu_pkg::KIND_END;
               phase_in  = jsu_pkg::PH_IDLE;
            end else if (in_byte == jsu_pkg::CH_BSLASH) begin
               if (in_final) begin
                  tail     = 1'b1;
                  tail_err = jsu_pkg::ERR_INCOMPLETE;
               end else begin
                  phase_in = jsu_pkg::PH_ESC;
               end
            end else if (in_byte < 8'h20) begin
               tail     = 1'b1;
               tail_err = jsu_pkg::ERR_CONTROL;
            end else begin
               dbytes[0]  = in_byte;
               nd         = 3'd1;
               after_data = 1'b1;
            end
         end
         jsu_pkg::PH_ESC: begin
            if (in_byte == jsu_pkg::CH_U) begin
               phase_in = jsu_pkg::PH_HEXHI;
               dig_in   = 2'd0;
               acc_in   = 16'h0000;
               if (in_final) begin
                  tail     = 1'b1;
                  tail_err = jsu_pkg::ERR_SHORT_HEX;
               end
            end else if (esc[8]) begin
               tail     = 1'b1;
               tail_err = jsu_pkg::ERR_BAD_ESCAPE;
            end else begin
               dbytes[0]  = esc[7:0];
               nd         = 3'd1;
               after_data = 1'b1;
            end
         end
         jsu_pkg::PH_HEXHI, jsu_pkg::PH_HEXLO: begin
            if (nib[4]) begin
               tail     = 1'b1;
               tail_err = jsu_pkg::ERR_BAD_HEX;
            end else if (dig_ff != 2'd3) begin
               acc_in = val;
               dig_in = dig_ff + 2'd1;
               if (in_final) begin
                  tail     = 1'b1;
                  tail_err = jsu_pkg::ERR_SHORT_HEX;
               end
            end else if (phase_ff == jsu_pkg::PH_HEXHI) begin
               if (val[15:10] == 6'b110110) begin
                  hs_in    = val[9:0];
                  dig_in   = 2'd0;
                  acc_in   = 16'h0000;
                  phase_in = jsu_pkg::PH_LOWBS;
                  if (in_final) begin
                     tail     = 1'b1;
                     tail_err = jsu_pkg::ERR_NO_LOW;
                  end
               end else if (val[15:10] == 6'b110111) begin
                  tail     = 1'b1;
                  tail_err = jsu_pkg::ERR_LONE_LOW;
               end else begin
                  after_data = 1'b1;
                  if (val < 16'h0080) begin
                     dbytes[0] = val[7:0];
                     nd        = 3'd1;
                  end else if (val < 16'h0800) begin
                     dbytes[0] = 8'hC0 | {3'b000, val[10:6]};
                     dbytes[1] = 8'h80 | {2'b00, val[5:0]};
                     nd        = 3'd2;
                  end else begin
                     dbytes[0] = 8'hE0 | {4'h0, val[15:12]};
                     dbytes[1] = 8'h80 | {2'b00, val[11:6]};
                     dbytes[2] = 8'h80 | {2'b00, val[5:0]};
                     nd        = 3'd3;
                  end
               end
            end else begin
               if (val[15:10] != 6'b110111) begin
                  tail     = 1'b1;
                  tail_err = jsu_pkg::ERR_BAD_LOW;
               end else begin
                  // A surrogate pair always lands in the four-byte range.
                  after_data = 1'b1;
                  dbytes[0]  = 8'hF0 | {5'b00000, cp[20:18]};
                  dbytes[1]  = 8'h80 | {2'b00, cp[17:12]};
                  dbytes[2]  = 8'h80 | {2'b00, cp[11:6]};
                  dbytes[3]  = 8'h80 | {2'b00, cp[5:0]};
                  nd         = 3'd4;
               end
            end
         end
         jsu_pkg::PH_LOWBS: begin
            if (in_byte == jsu_pkg::CH_BSLASH && !in_final) begin
               phase_in = jsu_pkg::PH_LOWU;
            end else begin
               tail     = 1'b1;
               tail_err = jsu_pkg::ERR_NO_LOW;
            end
         end
         jsu_pkg::PH_LOWU: begin
            if (in_byte == jsu_pkg::CH_U) begin
               phase_in = jsu_pkg::PH_HEXLO;
               dig_in   = 2'd0;
               acc_in   = 16'h0000;
               if (in_final) begin
                  tail     = 1'b1;
                  tail_err = jsu_pkg::ERR_SHORT_HEX;
               end
            end else begin
               tail     = 1'b1;
               tail_err = jsu_pkg::ERR_NO_LOW;
            end
         end
         default: begin
            dig_in = 2'd0;
            acc_in = 16'h0000;
            hs_in  = 10'd0;
            if (in_byte == jsu_pkg::CH_QUOTE) begin
               phase_in = jsu_pkg::PH_STR;
               if (in_final) begin
                  tail     = 1'b1;
                  tail_err = jsu_pkg::ERR_UNTERMINATED;
               end
            end else begin
               phase_in = jsu_pkg::PH_IDLE;
               tail     = 1'b1;
               tail_err = jsu_pkg::ERR_NO_QUOTE;
            end
         end
      endcase

      if (after_data) begin
         phase_in = jsu_pkg::PH_STR;
         dig_in   = 2'd0;
         acc_in   = 16'h0000;
         hs_in    = 10'd0;
         if (in_final) begin
            tail     = 1'b1;
            tail_err = jsu_pkg::ERR_UNTERMINATED;
         end
      end

      // Errors and the closing quote both leave the parser idle and clean.
      if (tail) begin
         phase_in = jsu_pkg::PH_IDLE;
         dig_in   = 2'd0;
         acc_in   = 16'h0000;
         hs_in    = 10'd0;
      end
      if (tail && tail_kind == jsu_pkg::KIND_END) begin
         tail_err = 4'd0;
      end
   end

   always_comb begin
      group.count = jsu_pkg::CountW'(nd) + jsu_pkg::CountW'(tail);
      for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
         group.items[i] = '0;
         if (i < int'(nd)) begin
            group.items[i].kind = jsu_pkg::KIND_DATA;
            group.items[i].data = dbytes[i % jsu_pkg::DataMax];
         end else if (i == int'(nd) && tail) begin
            group.items[i].kind = tail_kind;
            group.items[i].err  = tail_err;
         end
         group.items[i].last = (i + 1 == int'(group.count));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jsu_pkg::PH_IDLE;
         dig_ff   <= 2'd0;
         acc_ff   <= 16'h0000;
         hs_ff    <= 10'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         dig_ff   <= dig_in;
         acc_ff   <= acc_in;
         hs_ff    <= hs_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/jsu_serial.sv -----
`default_nettype none

module jsu_serial (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  jsu_pkg::group_type      push_group,
   output logic                    space,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output jsu_pkg::result_type     out_item
);

   jsu_pkg::group_type          slots_ff [2];
   logic                        wr_ptr_ff, wr_ptr_in;
   logic                        rd_ptr_ff, rd_ptr_in;
   logic [1:0]                  count_ff, count_in;
   logic [jsu_pkg::IdxW-1:0]    idx_ff, idx_in;
   logic                        pop_item, pop_group;

   assign space     = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slots_ff[rd_ptr_ff].items[idx_ff];
   assign pop_item  = out_valid && out_ready;
   assign pop_group = pop_item && out_item.last;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_group ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop_group);
      idx_in    = pop_group ? '0 : (pop_item ? idx_ff + jsu_pkg::IdxW'(1) : idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         idx_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_group;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> space)
      else $error("group pushed into a full buffer");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_item.kind != jsu_pkg::KIND_DATA |-> out_item.last)
      else $error("end or error result is not the last of its group");

   a_clean_fields: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_item.kind == jsu_pkg::KIND_DATA ? out_item.err == 4'd0
                                                          : out_item.data == 8'h00))
      else $error("unused result field is not zero");

   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> idx_ff < jsu_pkg::IdxW'(slots_ff[rd_ptr_ff].count))
      else $error("result index ran past its group");

endmodule

`default_nettype wire

// ----- hw/rtl/json_string_unescaper.sv -----
`default_nettype none

// JSON string unescaper. Source bytes enter on the req_ channel, one per
// transfer; decoded bytes, end markers and errors leave on the rsp_ channel.
// A source byte is registered, then decoded against the parser state, and
// all of its results (up to five) go as one group into a two-group output
// buffer that hands them out one per transfer. A new source byte can be
// taken every cycle while the buffer has room; the sustained rate is one
// source byte per cycle while bytes produce one result each and the
// receiver is ready, and a byte that produces k results takes k output
// transfers, so the output port sets the rate.
module json_string_unescaper (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_src_byte,
   input  wire logic        req_src_final,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_out_kind,
   output logic [7:0]       rsp_out_byte,
   output logic [3:0]       rsp_err_code,
   output logic             rsp_run_last
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_final_ff;
   logic                fire;
   logic                space;
   jsu_pkg::group_type  group;
   jsu_pkg::result_type item;

   // A byte with no results never needs buffer room.
   assign fire      = in_valid_ff && (group.count == '0 || space);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff && !fire;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_src_byte;
         in_final_ff <= req_src_final;
      end
   end

   jsu_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .in_byte  (in_byte_ff),
      .in_final (in_final_ff),
      .fire     (fire),
      .group    (group)
   );

   jsu_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .push       (fire && group.count != '0),
      .push_group (group),
      .space      (space),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_item   (item)
   );

   assign rsp_out_kind = item.kind;
   assign rsp_out_byte = item.data;
   assign rsp_err_code = item.err;
   assign rsp_run_last = item.last;

endmodule

`default_nettype wire
